// ===== hw/rtl/bba_pkg.sv =====
// Shared types, codes and default sizes for the buddy block allocator.
// Used by bba_ctrl, bba_datapath and buddy_block_allocator; no dependencies.
package bba_pkg;

    localparam int UNIT_TOTAL_DEF  = 8192;
    localparam int ORDER_COUNT_DEF = 9;
    localparam int TOP_ORDER_DEF   = 8;
    localparam int UNIT_SHIFT_DEF  = 16;

    localparam int ADDR_W = 48;
    localparam int SIZE_W = 25;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int TBC_W  = 6;
    localparam int ORD_W  = 4;
    localparam int CFG_IW = 1;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INIT  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNDEF = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FAIL = 2'd1;
    localparam logic [STAT_W-1:0] ST_DONE = 2'd2;

    localparam logic [CFG_IW-1:0] REG_HEAP_BASE = 1'd0;
    localparam logic [CFG_IW-1:0] REG_TOP_COUNT = 1'd1;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [SIZE_W-1:0] req_size;
        logic [ADDR_W-1:0] free_addr;
    } t_in;

    typedef struct packed {
        logic [ADDR_W-1:0] block_addr;
        logic [STAT_W-1:0] status;
    } t_out;

    // per-unit bookkeeping kept in the cleared memory
    typedef struct packed {
        logic             taken;
        logic [ORD_W-1:0] order;
        logic             link_ok;
    } t_meta;

    typedef enum logic [3:0] {
        OP_NONE   = 4'd0,
        OP_LATCH  = 4'd1,
        OP_CLEAR  = 4'd2,
        OP_AFIND  = 4'd3,
        OP_POP    = 4'd4,
        OP_SPLIT  = 4'd5,
        OP_FREE   = 4'd6,
        OP_FCHK   = 4'd7,
        OP_LOOP   = 4'd8,
        OP_BCHK   = 4'd9,
        OP_WALK   = 4'd10,
        OP_ABSORB = 4'd11,
        OP_PUSH   = 4'd12,
        OP_EMIT   = 4'd13
    } t_op;

    typedef struct packed {
        t_op op;
    } t_ctl;

    typedef struct packed {
        logic clr_last;
        logic a_fail;
        logic split_more;
        logic idx_bad;
        logic not_taken;
        logic loop_stop;
        logic b_stop;
        logic b_head;
        logic walk_end;
        logic walk_hit;
        logic out_free;
    } t_stat;

endpackage

// ===== hw/rtl/bba_ctrl.sv =====
// Sequencer for the buddy block allocator: one-hot state machine issuing datapath ops.
// Depends on bba_pkg.
module bba_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [bba_pkg::CMD_W-1:0]  i_in_cmd,
    output logic                       o_in_ready,
    input  bba_pkg::t_stat             i_stat,
    output bba_pkg::t_ctl              o_ctl
);

    typedef enum logic [12:0] {
        S_CLEAR  = 13'b0000000000001,
        S_IDLE   = 13'b0000000000010,
        S_AFIND  = 13'b0000000000100,
        S_POP    = 13'b0000000001000,
        S_SPLIT  = 13'b0000000010000,
        S_FREE   = 13'b0000000100000,
        S_FCHK   = 13'b0000001000000,
        S_LOOP   = 13'b0000010000000,
        S_BCHK   = 13'b0000100000000,
        S_WALK   = 13'b0001000000000,
        S_ABSORB = 13'b0010000000000,
        S_PUSH   = 13'b0100000000000,
        S_DONE   = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_reply, n_reply;

    always_comb begin
        n_state    = r_state;
        n_reply    = r_reply;
        o_ctl.op   = bba_pkg::OP_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_ctl.op = bba_pkg::OP_CLEAR;
                if (i_stat.clr_last) begin
                    n_state = r_reply ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.op = bba_pkg::OP_LATCH;
                    case (i_in_cmd)
                        bba_pkg::CMD_ALLOC: n_state = S_AFIND;
                        bba_pkg::CMD_FREE:  n_state = S_FREE;
                        bba_pkg::CMD_INIT: begin
                            n_state = S_CLEAR;
                            n_reply = 1'b1;
                        end
                        default:            n_state = S_DONE;
                    endcase
                end
            end
            S_AFIND: begin
                o_ctl.op = bba_pkg::OP_AFIND;
                n_state  = i_stat.a_fail ? S_DONE : S_POP;
            end
            S_POP: begin
                o_ctl.op = bba_pkg::OP_POP;
                n_state  = S_SPLIT;
            end
            S_SPLIT: begin
                o_ctl.op = bba_pkg::OP_SPLIT;
                if (!i_stat.split_more) begin
                    n_state = S_DONE;
                end
            end
            S_FREE: begin
                o_ctl.op = bba_pkg::OP_FREE;
                n_state  = i_stat.idx_bad ? S_DONE : S_FCHK;
            end
            S_FCHK: begin
                o_ctl.op = bba_pkg::OP_FCHK;
                n_state  = i_stat.not_taken ? S_DONE : S_LOOP;
            end
            S_LOOP: begin
                o_ctl.op = bba_pkg::OP_LOOP;
                n_state  = i_stat.loop_stop ? S_PUSH : S_BCHK;
            end
            S_BCHK: begin
                o_ctl.op = bba_pkg::OP_BCHK;
                if (i_stat.b_stop) begin
                    n_state = S_PUSH;
                end else if (i_stat.b_head) begin
                    n_state = S_ABSORB;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                o_ctl.op = bba_pkg::OP_WALK;
                if (i_stat.walk_hit) begin
                    n_state = S_ABSORB;
                end else if (i_stat.walk_end) begin
                    n_state = S_PUSH;
                end
            end
            S_ABSORB: begin
                o_ctl.op = bba_pkg::OP_ABSORB;
                n_state  = S_LOOP;
            end
            S_PUSH: begin
                o_ctl.op = bba_pkg::OP_PUSH;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_ctl.op = bba_pkg::OP_EMIT;
                    n_state  = S_IDLE;
                    n_reply  = 1'b0;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_reply <= 1'b0;
        end else begin
            r_state <= n_state;
            r_reply <= n_reply;
        end
    end

endmodule

// ===== hw/rtl/bba_datapath.sv =====
// Datapath of the buddy block allocator: unit memories, free-list heads, config and output word.
// Depends on bba_pkg; driven by op codes from bba_ctrl.
module bba_datapath #(
    parameter int UNIT_TOTAL  = bba_pkg::UNIT_TOTAL_DEF,
    parameter int ORDER_COUNT = bba_pkg::ORDER_COUNT_DEF,
    parameter int TOP_ORDER   = bba_pkg::TOP_ORDER_DEF,
    parameter int UNIT_SHIFT  = bba_pkg::UNIT_SHIFT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bba_pkg::t_ctl               i_ctl,
    output bba_pkg::t_stat              o_stat,
    input  bba_pkg::t_in                i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output bba_pkg::t_out               o_out_data,
    input  logic                        i_cfg_we,
    input  logic [bba_pkg::CFG_IW-1:0]  i_cfg_idx,
    input  logic [bba_pkg::ADDR_W-1:0]  i_cfg_data
);

    localparam int UW   = $clog2(UNIT_TOTAL);
    localparam int OIW  = $clog2(ORDER_COUNT);
    localparam int MAXN = UNIT_TOTAL >> TOP_ORDER;
    localparam int NW   = $clog2(MAXN + 1);
    localparam int AW   = bba_pkg::ADDR_W;
    localparam int OW   = bba_pkg::ORD_W;
    localparam int HW   = AW - UNIT_SHIFT;

    // unit memories
    bba_pkg::t_meta m_meta [UNIT_TOTAL];
    logic [UW-1:0]  m_link [UNIT_TOTAL];
    bba_pkg::t_meta r_rd_meta;
    logic [UW-1:0]  r_rd_link;

    logic           mem_re;
    logic [UW-1:0]  mem_ra;
    logic           meta_we;
    logic [UW-1:0]  meta_wa;
    bba_pkg::t_meta meta_wd;
    logic           link_we;
    logic [UW-1:0]  link_wa;
    logic [UW-1:0]  link_wd;

    logic [AW-1:0]                 r_base;
    logic [bba_pkg::TBC_W-1:0]     r_tbc;
    logic [bba_pkg::SIZE_W-1:0]    r_size;
    logic [AW-1:0]                 r_faddr;
    logic [NW-1:0]                 r_n;
    logic [UW-1:0]                 r_clr;
    logic [UW-1:0]                 r_u;
    logic [UW-1:0]                 r_b;
    logic [UW-1:0]                 r_cur;
    logic [UW-1:0]                 r_blink;
    logic                          r_bok;
    logic [OIW-1:0]                r_j;
    logic [OIW-1:0]                r_o;
    logic [OIW-1:0]                r_want;
    logic [UW-1:0]                 r_head [ORDER_COUNT];
    logic [ORDER_COUNT-1:0]        r_hok;
    bba_pkg::t_out                 r_res;
    bba_pkg::t_out                 r_out;
    logic                          r_out_valid;

    logic [63:0]    c_size;
    logic           c_size_bad;
    logic [OIW-1:0] c_want;
    logic           c_found;
    logic [OIW-1:0] c_j;
    logic [AW-1:0]  c_diff;
    logic [HW-1:0]  c_hi;
    logic           c_idx_bad;
    logic [UW:0]    c_bw;
    logic [UW-1:0]  c_b;
    logic [OIW-1:0] c_min;
    logic [OIW-1:0] c_jm;
    logic [UW-1:0]  c_sb;
    logic           c_top;
    logic           c_tok;
    logic [UW-1:0]  c_tlink;
    logic [NW-1:0]  c_n;

    always_comb begin
        c_size     = 64'(r_size);
        c_size_bad = c_size > (64'd1 << (UNIT_SHIFT + TOP_ORDER));
        c_want     = OIW'(TOP_ORDER);
        for (int w = TOP_ORDER; w >= 0; w--) begin
            if (c_size <= (64'd1 << (UNIT_SHIFT + w))) c_want = OIW'(w);
        end
        // smallest non-empty list at or above the wanted order
        c_found = 1'b0;
        c_j     = '0;
        for (int w = TOP_ORDER; w >= 0; w--) begin
            if (r_hok[w] && w >= int'(c_want)) begin
                c_found = 1'b1;
                c_j     = OIW'(w);
            end
        end
        c_diff    = r_faddr - r_base;
        c_hi      = c_diff[AW-1:UNIT_SHIFT];
        c_idx_bad = c_hi >= HW'(UNIT_TOTAL);
        c_bw      = {1'b0, r_u} ^ ((UW+1)'(1) << r_o);
        c_b       = c_bw[UW-1:0];
        c_min     = (r_rd_meta.order > OW'(TOP_ORDER)) ? OIW'(TOP_ORDER)
                                                      : OIW'(r_rd_meta.order);
        c_jm      = r_j - OIW'(1);
        c_sb      = r_u + (UW'(1) << c_jm);
        c_top     = (r_clr[TOP_ORDER-1:0] == '0) &&
                    (int'(r_clr[UW-1:TOP_ORDER]) < int'(r_n));
        c_tok     = (int'(r_clr[UW-1:TOP_ORDER]) + 1) < int'(r_n);
        c_tlink   = r_clr + (UW'(1) << TOP_ORDER);
        c_n       = (int'(r_tbc) > MAXN) ? NW'(MAXN) : NW'(r_tbc);
    end

    always_comb begin
        o_stat.clr_last   = r_clr == UW'(UNIT_TOTAL - 1);
        o_stat.a_fail     = c_size_bad || !c_found;
        o_stat.split_more = r_j > r_want;
        o_stat.idx_bad    = c_idx_bad;
        o_stat.not_taken  = !r_rd_meta.taken;
        o_stat.loop_stop  = (r_o >= OIW'(TOP_ORDER)) || (c_bw >= (UW+1)'(UNIT_TOTAL));
        o_stat.b_stop     = r_rd_meta.taken || (r_rd_meta.order != OW'(r_o)) || !r_hok[r_o];
        o_stat.b_head     = r_head[r_o] == r_b;
        o_stat.walk_end   = !r_rd_meta.link_ok;
        o_stat.walk_hit   = r_rd_meta.link_ok && (r_rd_link == r_b);
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    // memory port selection per op
    always_comb begin
        mem_re  = 1'b0;
        mem_ra  = '0;
        meta_we = 1'b0;
        meta_wa = r_u;
        meta_wd = '0;
        link_we = 1'b0;
        link_wa = r_u;
        link_wd = r_head[r_o];
        case (i_ctl.op)
            bba_pkg::OP_CLEAR: begin
                meta_we = 1'b1;
                meta_wa = r_clr;
                meta_wd = '{taken: 1'b0, order: c_top ? OW'(TOP_ORDER) : '0,
                            link_ok: c_top && c_tok};
                link_we = c_top;
                link_wa = r_clr;
                link_wd = c_tlink;
            end
            bba_pkg::OP_AFIND: begin
                mem_re = !o_stat.a_fail;
                mem_ra = r_head[c_j];
            end
            bba_pkg::OP_SPLIT: begin
                meta_we = 1'b1;
                if (o_stat.split_more) begin
                    meta_wa = c_sb;
                    meta_wd = '{taken: 1'b0, order: OW'(c_jm), link_ok: r_hok[c_jm]};
                    link_we = 1'b1;
                    link_wa = c_sb;
                    link_wd = r_head[c_jm];
                end else begin
                    meta_wa = r_u;
                    meta_wd = '{taken: 1'b1, order: OW'(r_want), link_ok: 1'b0};
                end
            end
            bba_pkg::OP_FREE: begin
                mem_re = !c_idx_bad;
                mem_ra = c_hi[UW-1:0];
            end
            bba_pkg::OP_LOOP: begin
                mem_re = !o_stat.loop_stop;
                mem_ra = c_b;
            end
            bba_pkg::OP_BCHK: begin
                mem_re = !o_stat.b_stop && !o_stat.b_head;
                mem_ra = r_head[r_o];
            end
            bba_pkg::OP_WALK: begin
                if (o_stat.walk_hit) begin
                    // unlink the buddy behind its predecessor
                    meta_we = 1'b1;
                    meta_wa = r_cur;
                    meta_wd = '{taken: r_rd_meta.taken, order: r_rd_meta.order,
                                link_ok: r_bok};
                    link_we = 1'b1;
                    link_wa = r_cur;
                    link_wd = r_blink;
                end else if (!o_stat.walk_end) begin
                    mem_re = 1'b1;
                    mem_ra = r_rd_link;
                end
            end
            bba_pkg::OP_ABSORB: begin
                meta_we = 1'b1;
                meta_wa = (r_b < r_u) ? r_u : r_b;
            end
            bba_pkg::OP_PUSH: begin
                meta_we = 1'b1;
                meta_wa = r_u;
                meta_wd = '{taken: 1'b0, order: OW'(r_o), link_ok: r_hok[r_o]};
                link_we = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (meta_we) m_meta[meta_wa] <= meta_wd;
        if (link_we) m_link[link_wa] <= link_wd;
        if (mem_re) begin
            r_rd_meta <= m_meta[mem_ra];
            r_rd_link <= m_link[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_tbc       <= bba_pkg::TBC_W'(1);
            r_hok       <= '0;
            r_clr       <= '0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bba_pkg::REG_HEAP_BASE: r_base <= i_cfg_data;
                    bba_pkg::REG_TOP_COUNT: r_tbc  <= i_cfg_data[bba_pkg::TBC_W-1:0];
                    default: ;
                endcase
            end
            if (i_ctl.op == bba_pkg::OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_ctl.op)
                bba_pkg::OP_LATCH: begin
                    r_size  <= i_in_data.req_size;
                    r_faddr <= i_in_data.free_addr;
                    r_res   <= '{block_addr: '0, status: bba_pkg::ST_DONE};
                    if (i_in_data.cmd == bba_pkg::CMD_INIT) begin
                        r_n                <= c_n;
                        r_hok              <= (c_n != '0) ? (ORDER_COUNT'(1) << TOP_ORDER)
                                                          : '0;
                        r_head[TOP_ORDER]  <= '0;
                    end
                end
                bba_pkg::OP_CLEAR: begin
                    r_clr <= o_stat.clr_last ? '0 : r_clr + UW'(1);
                end
                bba_pkg::OP_AFIND: begin
                    r_want <= c_want;
                    if (o_stat.a_fail) begin
                        r_res.status <= bba_pkg::ST_FAIL;
                    end else begin
                        r_j <= c_j;
                        r_u <= r_head[c_j];
                    end
                end
                bba_pkg::OP_POP: begin
                    r_head[r_j] <= r_rd_link;
                    r_hok[r_j]  <= r_rd_meta.link_ok;
                end
                bba_pkg::OP_SPLIT: begin
                    if (o_stat.split_more) begin
                        r_j          <= c_jm;
                        r_head[c_jm] <= c_sb;
                        r_hok[c_jm]  <= 1'b1;
                    end else begin
                        r_res <= '{block_addr: r_base + (AW'(r_u) << UNIT_SHIFT),
                                   status: bba_pkg::ST_OK};
                    end
                end
                bba_pkg::OP_FREE: r_u <= c_hi[UW-1:0];
                bba_pkg::OP_FCHK: r_o <= c_min;
                bba_pkg::OP_LOOP: r_b <= c_b;
                bba_pkg::OP_BCHK: begin
                    r_blink <= r_rd_link;
                    r_bok   <= r_rd_meta.link_ok;
                    if (!o_stat.b_stop) begin
                        if (o_stat.b_head) begin
                            r_head[r_o] <= r_rd_link;
                            r_hok[r_o]  <= r_rd_meta.link_ok;
                        end else begin
                            r_cur <= r_head[r_o];
                        end
                    end
                end
                bba_pkg::OP_WALK: begin
                    if (!o_stat.walk_hit && !o_stat.walk_end) r_cur <= r_rd_link;
                end
                bba_pkg::OP_ABSORB: begin
                    if (r_b < r_u) r_u <= r_b;
                    r_o <= r_o + OIW'(1);
                end
                bba_pkg::OP_PUSH: begin
                    r_head[r_o] <= r_u;
                    r_hok[r_o]  <= 1'b1;
                end
                bba_pkg::OP_EMIT: begin
                    r_out <= r_res;
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== hw/rtl/buddy_block_allocator.sv =====
// Top level of the buddy block allocator: sequencer plus datapath.
// Depends on bba_pkg, bba_ctrl and bba_datapath.
//
//  channel   direction  handshake                    payload
//  request   in         i_in_valid / o_in_ready      i_in_data  (cmd, req_size, free_addr)
//  result    out        o_out_valid / i_out_ready    o_out_data (block_addr, status)
//  config    in         i_cfg_we                     i_cfg_idx, i_cfg_data
//
// Allocate searches the free lists, pops a block and splits it down one order per split; it
// fails at the search. Free checks the unit, then loops over buddy checks, list walks and
// merges until the merging stops, and pushes the block; it ends early when the unit is
// out of range or not taken. Init runs a one-entry-per-cycle sweep over unit memory.
// After reset the same sweep runs before the first word is accepted.
// One word is in work at a time; a full output register stalls only the emit of the next.
module buddy_block_allocator #(
    parameter int UNIT_TOTAL  = bba_pkg::UNIT_TOTAL_DEF,
    parameter int ORDER_COUNT = bba_pkg::ORDER_COUNT_DEF,
    parameter int TOP_ORDER   = bba_pkg::TOP_ORDER_DEF,
    parameter int UNIT_SHIFT  = bba_pkg::UNIT_SHIFT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  bba_pkg::t_in                i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output bba_pkg::t_out               o_out_data,
    input  logic                        i_cfg_we,
    input  logic [bba_pkg::CFG_IW-1:0]  i_cfg_idx,
    input  logic [bba_pkg::ADDR_W-1:0]  i_cfg_data
);

    bba_pkg::t_ctl  ctl;
    bba_pkg::t_stat stat;

    bba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_cmd   (i_in_data.cmd),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_ctl      (ctl)
    );

    bba_datapath #(
        .UNIT_TOTAL  (UNIT_TOTAL),
        .ORDER_COUNT (ORDER_COUNT),
        .TOP_ORDER   (TOP_ORDER),
        .UNIT_SHIFT  (UNIT_SHIFT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_stat      (stat),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // failed or non-allocate words carry a zero address
    a_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != bba_pkg::ST_OK) |-> o_out_data.block_addr == '0)
        else $error("nonzero address on non-allocated result");

    // only one word in work: ready drops after an accept
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request accepted while busy");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == bba_pkg::ST_OK) ||
                        (o_out_data.status == bba_pkg::ST_FAIL) ||
                        (o_out_data.status == bba_pkg::ST_DONE))
        else $error("undefined status code");

    // an emit only happens when the output register can take it
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.op == bba_pkg::OP_EMIT) |-> stat.out_free)
        else $error("result overwritten");

endmodule
